>>> rtl/core/tcli_pkg.sv
// Package for the trie child lookup/insert unit: table sizes, codes, shared types.
// No dependencies; every other file of the unit imports it.
package tcli_pkg;

   localparam int MAX_NODES     = 4096;
   localparam int ADDR_WIDTH    = $clog2(MAX_NODES);
   localparam int COUNT_WIDTH   = ADDR_WIDTH + 1;
   localparam int NODE_ID_WIDTH = 13;
   localparam int KEY_WIDTH     = 32;
   localparam int STATUS_WIDTH  = 2;

   localparam logic [NODE_ID_WIDTH-1:0] ROOT_ID = '1;
   localparam logic [NODE_ID_WIDTH-1:0] NO_NODE = '1;

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_NO_PARENT = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [NODE_ID_WIDTH-1:0] parent;
      logic [KEY_WIDTH-1:0]     key;
   } node_entry_type;

   typedef struct packed {
      logic                  en;
      logic [ADDR_WIDTH-1:0] addr;
      node_entry_type        data;
   } mem_wr_type;

   typedef struct packed {
      logic                     hit;
      logic                     miss;
      logic [NODE_ID_WIDTH-1:0] hit_id;
   } scan_stat_type;

endpackage

>>> rtl/core/tcli_if.sv
// Valid/ready channel interfaces for requests and responses of the trie unit.
// Depends on tcli_pkg for field widths.
interface tcli_req_if;
   import tcli_pkg::*;

   logic                            valid;
   logic                            ready;
   logic                            opcode;
   logic signed [NODE_ID_WIDTH-1:0] parent_node;
   logic signed [KEY_WIDTH-1:0]     lookup_key;

   modport source (output valid, output opcode, output parent_node, output lookup_key,
                   input ready);
   modport sink   (input valid, input opcode, input parent_node, input lookup_key,
                   output ready);
endinterface

interface tcli_rsp_if;
   import tcli_pkg::*;

   logic                            valid;
   logic                            ready;
   logic                            found;
   logic signed [NODE_ID_WIDTH-1:0] node_id;
   logic [STATUS_WIDTH-1:0]         status;

   modport source (output valid, output found, output node_id, output status,
                   input ready);
   modport sink   (input valid, input found, input node_id, input status,
                   output ready);
endinterface

>>> rtl/core/tcli_node_mem.sv
// Node table: one write port, one registered read port, parent and key per node.
// Depends on tcli_pkg.
module tcli_node_mem (
   input  logic                      clock,
   input  tcli_pkg::mem_wr_type      wr,
   input  logic                      rd_en,
   input  logic [tcli_pkg::ADDR_WIDTH-1:0] rd_addr,
   output tcli_pkg::node_entry_type  rd_data
);
   import tcli_pkg::*;

   node_entry_type mem [MAX_NODES];
   node_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/tcli_scan.sv
// Child search: walks node ids from zero up to the node count, one read per cycle while run is high,
// and compares each entry with the wanted parent and key. Depends on tcli_pkg.
module tcli_scan (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            run,
   input  logic [tcli_pkg::NODE_ID_WIDTH-1:0] tgt_parent,
   input  logic [tcli_pkg::KEY_WIDTH-1:0]  tgt_key,
   input  logic [tcli_pkg::COUNT_WIDTH-1:0] limit,
   input  tcli_pkg::node_entry_type        rd_data,
   output logic                            rd_en,
   output logic [tcli_pkg::ADDR_WIDTH-1:0] rd_addr,
   output tcli_pkg::scan_stat_type         stat
);
   import tcli_pkg::*;

   logic [COUNT_WIDTH-1:0]   idx_ff, idx_in;
   logic                     pend_ff, pend_in;
   logic [ADDR_WIDTH-1:0]    pend_addr_ff, pend_addr_in;
   logic [COUNT_WIDTH-1:0]   limit_ff, limit_in;
   node_entry_type           tgt_ff, tgt_in;
   logic                     match;

   assign match   = pend_ff && (rd_data == tgt_ff);
   assign rd_en   = run && (idx_ff < limit_ff);
   assign rd_addr = idx_ff[ADDR_WIDTH-1:0];

   always_comb begin
      stat.hit    = run && match;
      stat.miss   = run && !pend_ff && (idx_ff == limit_ff);
      stat.hit_id = NODE_ID_WIDTH'(pend_addr_ff);
   end

   always_comb begin
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      limit_in     = limit_ff;
      tgt_in       = tgt_ff;
      if (start) begin
         idx_in      = '0;
         pend_in     = 1'b0;
         limit_in    = limit;
         tgt_in      = '{parent: tgt_parent, key: tgt_key};
      end else if (run) begin
         pend_in      = rd_en;
         pend_addr_in = idx_ff[ADDR_WIDTH-1:0];
         if (rd_en) begin
            idx_in = idx_ff + COUNT_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         pend_ff <= pend_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      limit_ff     <= limit_in;
      tgt_ff       <= tgt_in;
   end

endmodule

>>> rtl/core/trie_child_lookup_insert_unit.sv
// Top level of the trie child lookup/insert unit: sequencer, node count, result register.
// Depends on tcli_pkg, tcli_if, tcli_node_mem and tcli_scan.
//
//   port      dir   flow           carries
//   req_chan  in    valid/ready    opcode, parent_node, lookup_key
//   rsp_chan  out   valid/ready    found, node_id, status
//
// From accept to the output register an item passes the scan and emit states: a miss
// walks all node_count entries, a hit stops at node k, an empty table reads nothing and
// an unknown parent skips the scan; the sequencer returns to idle before the next accept.
// The walk is linear over the node table, one read per cycle on its single read port.
// Reset clears the node count, the sequencer and the result valid; the table
// needs no clearing. A result waiting for rsp_chan.ready does not block the
// next request, which waits only in ST_EMIT to load the output register.
module trie_child_lookup_insert_unit (
   input  logic      clock,
   input  logic      reset,
   tcli_req_if.sink  req_chan,
   tcli_rsp_if.source rsp_chan
);
   import tcli_pkg::*;

   state_type               state_ff, state_in;
   logic [COUNT_WIDTH-1:0]  count_ff, count_in;
   logic                    op_ff;
   logic [NODE_ID_WIDTH-1:0] parent_ff, parent_norm;
   logic [KEY_WIDTH-1:0]    key_ff;
   logic                    res_found_ff, res_found_in;
   logic [NODE_ID_WIDTH-1:0] res_id_ff, res_id_in;
   logic [STATUS_WIDTH-1:0] res_status_ff, res_status_in;
   logic                    res_load;
   logic                    out_valid_ff, out_valid_in;
   logic                    out_found_ff;
   logic [NODE_ID_WIDTH-1:0] out_id_ff;
   logic [STATUS_WIDTH-1:0] out_status_ff;
   logic                    accept, no_parent, table_full, out_free, out_load;
   logic                    scan_start, scan_run, rd_en;
   logic [ADDR_WIDTH-1:0]   rd_addr;
   node_entry_type          rd_data;
   mem_wr_type              mem_wr;
   scan_stat_type           stat;

   assign accept      = req_chan.valid && req_chan.ready;
   assign parent_norm = req_chan.parent_node[NODE_ID_WIDTH-1] ? ROOT_ID
                                                              : req_chan.parent_node;
   assign no_parent   = !req_chan.parent_node[NODE_ID_WIDTH-1]
                        && (COUNT_WIDTH'($unsigned(req_chan.parent_node)) >= count_ff);
   assign table_full  = (count_ff == COUNT_WIDTH'(MAX_NODES));
   assign out_free    = !out_valid_ff || rsp_chan.ready;

   tcli_node_mem u_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tcli_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .start      (scan_start),
      .run        (scan_run),
      .tgt_parent (parent_norm),
      .tgt_key    (req_chan.lookup_key),
      .limit      (count_ff),
      .rd_data    (rd_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .stat       (stat)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = no_parent ? ST_EMIT : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.hit || stat.miss) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_chan.ready = 1'b0;
      scan_start     = 1'b0;
      scan_run       = 1'b0;
      res_load       = 1'b0;
      res_found_in   = 1'b0;
      res_id_in      = NO_NODE;
      res_status_in  = STATUS_OK;
      mem_wr.en      = 1'b0;
      mem_wr.addr    = count_ff[ADDR_WIDTH-1:0];
      mem_wr.data    = '{parent: parent_ff, key: key_ff};
      count_in       = count_ff;
      out_load       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               if (no_parent) begin
                  res_load      = 1'b1;
                  res_status_in = STATUS_NO_PARENT;
               end else begin
                  scan_start = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            scan_run = 1'b1;
            priority if (stat.hit) begin
               res_load     = 1'b1;
               res_found_in = 1'b1;
               res_id_in    = stat.hit_id;
            end else if (stat.miss) begin
               res_load = 1'b1;
               priority if (op_ff == OP_LOOKUP) begin
                  res_status_in = STATUS_OK;
               end else if (table_full) begin
                  res_status_in = STATUS_FULL;
               end else begin
                  mem_wr.en = 1'b1;
                  count_in  = count_ff + COUNT_WIDTH'(1);
                  res_id_in = NODE_ID_WIDTH'(count_ff);
               end
            end else begin
               res_load = 1'b0;
            end
         end
         ST_EMIT: begin
            out_load = out_free;
         end
         default: begin
            out_load = 1'b0;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_chan.opcode;
         parent_ff <= parent_norm;
         key_ff    <= req_chan.lookup_key;
      end
      if (res_load) begin
         res_found_ff  <= res_found_in;
         res_id_ff     <= res_id_in;
         res_status_ff <= res_status_in;
      end
      if (out_load) begin
         out_found_ff  <= res_found_ff;
         out_id_ff     <= res_id_ff;
         out_status_ff <= res_status_ff;
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.found   = out_found_ff;
   assign rsp_chan.node_id = out_id_ff;
   assign rsp_chan.status  = out_status_ff;

endmodule

>>> rtl/core/tcli_checker.sv
// Port-level checks for the trie child lookup/insert unit, bound to its top level.
// Depends on tcli_pkg and trie_child_lookup_insert_unit.
module tcli_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            rsp_found,
   input logic [tcli_pkg::NODE_ID_WIDTH-1:0] rsp_node_id,
   input logic [tcli_pkg::STATUS_WIDTH-1:0]  rsp_status
);
   import tcli_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response item dropped before it was taken");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another item is in work");

   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_status == STATUS_OK && !rsp_node_id[NODE_ID_WIDTH-1])
      else $error("found child without ok status or valid id");

   a_err_no_node: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> !rsp_found && rsp_node_id == NO_NODE)
      else $error("error response carries a node");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == STATUS_OK || rsp_status == STATUS_FULL
                    || rsp_status == STATUS_NO_PARENT)
      else $error("undefined status code");

endmodule

bind trie_child_lookup_insert_unit tcli_checker u_tcli_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_found   (rsp_chan.found),
   .rsp_node_id (rsp_chan.node_id),
   .rsp_status  (rsp_chan.status)
);

>>> dv/trie_lookup_checker.sv
// Checker for the trie child lookup/insert unit: watches both channels, predicts each result.
// Depends on tcli_pkg and the tcli_req_if / tcli_rsp_if interfaces.
`timescale 1ns / 1ps

module trie_lookup_checker (
   input  logic clock,
   input  logic reset,
   tcli_req_if  req_mon,
   tcli_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending,
   output int   node_total
);
   import tcli_pkg::*;

   typedef struct packed {
      logic                     found;
      logic [NODE_ID_WIDTH-1:0] node_id;
      logic [STATUS_WIDTH-1:0]  status;
   } child_result_type;

   logic [KEY_WIDTH-1:0]     key_table [MAX_NODES];
   logic [NODE_ID_WIDTH-1:0] parent_table [MAX_NODES];
   int                       allocated = 0;
   int                       errors = 0;
   child_result_type         expected_children [$];

   function automatic child_result_type resolve_child(input logic op,
                                                      input logic signed [NODE_ID_WIDTH-1:0] parent,
                                                      input logic [KEY_WIDTH-1:0] key);
      child_result_type         r;
      logic [NODE_ID_WIDTH-1:0] owner;
      r.found   = 1'b0;
      r.node_id = NO_NODE;
      r.status  = STATUS_OK;
      if (parent < 0) begin
         owner = ROOT_ID;
      end else if (int'(parent) >= allocated) begin
         r.status = STATUS_NO_PARENT;
         return r;
      end else begin
         owner = parent;
      end
      for (int i = 0; i < allocated; i++) begin
         if (parent_table[i] == owner && key_table[i] == key) begin
            r.found   = 1'b1;
            r.node_id = NODE_ID_WIDTH'(i);
            return r;
         end
      end
      if (op == OP_LOOKUP) return r;
      if (allocated >= MAX_NODES) begin
         r.status = STATUS_FULL;
         return r;
      end
      key_table[allocated]    = key;
      parent_table[allocated] = owner;
      r.node_id = NODE_ID_WIDTH'(allocated);
      allocated++;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t: %s", $time, msg);
      errors++;
   endtask

   always @(posedge clock) begin
      child_result_type want;
      if (reset) begin
         allocated = 0;
         expected_children.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_children.size() == 0) begin
               report_mismatch($sformatf("unexpected result found %0d node_id %0d status %0d",
                                         rsp_mon.found, rsp_mon.node_id, rsp_mon.status));
            end else begin
               want = expected_children.pop_front();
               if (rsp_mon.found !== want.found)
                  report_mismatch($sformatf("found expected %0d got %0d",
                                            want.found, rsp_mon.found));
               if (rsp_mon.node_id !== want.node_id)
                  report_mismatch($sformatf("node_id expected %0d got %0d",
                                            $signed(want.node_id), rsp_mon.node_id));
               if (rsp_mon.status !== want.status)
                  report_mismatch($sformatf("status expected %0d got %0d",
                                            want.status, rsp_mon.status));
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_children.push_back(resolve_child(req_mon.opcode, req_mon.parent_node,
                                                      req_mon.lookup_key));
      end
      fail_count <= errors;
      pending    <= expected_children.size();
      node_total <= allocated;
   end

endmodule

>>> dv/tb_trie_child_lookup_insert_unit.sv
// Testbench top for the trie child lookup/insert unit: clock, reset, stimulus and verdict.
// Depends on tcli_pkg, the channel interfaces, the unit and trie_lookup_checker.
`timescale 1ns / 1ps

module tb_trie_child_lookup_insert_unit;
   import tcli_pkg::*;

   localparam int ITEMS_PER_PHASE = 580;
   localparam int GROW_CAP        = 384;
   localparam int HOLD_CYCLES     = 3000;
   localparam int WATCHDOG_LIMIT  = 20000;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   node_total;
   int   send_idle;
   int   recv_idle;
   bit   hold_off;
   int   idle_cycles;

   logic [KEY_WIDTH-1:0] key_pool [12] = '{
      32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
      32'h0000_0001, 32'h8000_0001, 32'h7FFF_FFFE, 32'h5555_5555,
      32'hAAAA_AAAA, 32'h0000_0010, 32'hFFFF_FF00, 32'h1234_5678
   };

   tcli_req_if req_chan ();
   tcli_rsp_if rsp_chan ();

   trie_child_lookup_insert_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   trie_lookup_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .fail_count (fail_count),
      .pending    (pending),
      .node_total (node_total)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic offer_request(input logic op, input logic [NODE_ID_WIDTH-1:0] parent,
                                input logic [KEY_WIDTH-1:0] key);
      bit taken;
      while ($urandom_range(99) < send_idle) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.opcode      <= op;
      req_chan.parent_node <= parent;
      req_chan.lookup_key  <= key;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = req_chan.ready;
         @(posedge clock);
      end
   endtask

   task automatic pick_request(output logic op, output logic [NODE_ID_WIDTH-1:0] parent,
                               output logic [KEY_WIDTH-1:0] key);
      int cnt;
      int r;
      cnt = node_total;
      r = $urandom_range(99);
      op = ($urandom_range(99) < 55) ? OP_INSERT : OP_LOOKUP;
      if (r < 8 && cnt < MAX_NODES)
         parent = NODE_ID_WIDTH'($urandom_range(MAX_NODES - 1, cnt));
      else if (r < 12)
         parent = NODE_ID_WIDTH'(-$urandom_range(4096, 2));
      else if (r < 35 || cnt == 0)
         parent = ROOT_ID;
      else if (r < 75)
         parent = NODE_ID_WIDTH'($urandom_range(((cnt < 8) ? cnt : 8) - 1, 0));
      else
         parent = NODE_ID_WIDTH'($urandom_range(cnt - 1, 0));
      key = ($urandom_range(99) < 55) ? key_pool[$urandom_range(11, 0)] : $urandom;
      // hold the trie small once it has grown: new nodes only under ids 0 to 7 or the root, with pool keys
      if (op == OP_INSERT && cnt >= GROW_CAP) begin
         key = key_pool[$urandom_range(11, 0)];
         if (!parent[NODE_ID_WIDTH-1] && int'(parent) < cnt && parent >= 8)
            parent = parent & 13'h7;
      end
   endtask

   task automatic drain_results;
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic run_phase(input int sidle, input int ridle, input int count);
      logic                     op;
      logic [NODE_ID_WIDTH-1:0] parent;
      logic [KEY_WIDTH-1:0]     key;
      send_idle = sidle;
      recv_idle = ridle;
      for (int n = 0; n < count; n++) begin
         pick_request(op, parent, key);
         offer_request(op, parent, key);
      end
      drain_results();
   endtask

   initial begin
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.opcode      = OP_LOOKUP;
      req_chan.parent_node = '0;
      req_chan.lookup_key  = '0;
      hold_off             = 1'b0;
      send_idle            = 19;
      recv_idle            = 88;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      offer_request(OP_LOOKUP, ROOT_ID, 32'h0000_0000);
      offer_request(OP_LOOKUP, 13'h0000, 32'h0000_0000);
      offer_request(OP_INSERT, 13'h0005, 32'h0000_0000);
      offer_request(OP_INSERT, ROOT_ID, 32'h8000_0000);
      offer_request(OP_INSERT, ROOT_ID, 32'h8000_0000);
      offer_request(OP_LOOKUP, ROOT_ID, 32'h8000_0000);
      offer_request(OP_INSERT, 13'h1000, 32'h7FFF_FFFF);
      offer_request(OP_LOOKUP, ROOT_ID, 32'h7FFF_FFFF);
      offer_request(OP_INSERT, 13'h0000, 32'h7FFF_FFFF);
      offer_request(OP_INSERT, 13'h0002, 32'h0000_0000);
      offer_request(OP_INSERT, 13'h0003, 32'hFFFF_FFFF);
      offer_request(OP_LOOKUP, 13'h0004, 32'hFFFF_FFFF);
      offer_request(OP_LOOKUP, 13'h0003, 32'hFFFF_FFFF);
      offer_request(OP_INSERT, 13'h0FFF, 32'h0000_0000);
      offer_request(OP_LOOKUP, 13'h0005, 32'h0000_0000);
      offer_request(OP_INSERT, 13'h0004, 32'hFFFF_FFFF);
      offer_request(OP_LOOKUP, 13'h1FFE, 32'h7FFF_FFFF);
      offer_request(OP_INSERT, 13'h1FFE, 32'h7FFF_FFFF);
      offer_request(OP_LOOKUP, 13'h0000, 32'h7FFF_FFFF);
      offer_request(OP_INSERT, 13'h0005, 32'h0000_0000);

      run_phase(19, 88, ITEMS_PER_PHASE);
      run_phase(88, 19, ITEMS_PER_PHASE);
      hold_off = 1'b1;
      run_phase(0, 0, ITEMS_PER_PHASE);

      repeat (node_total + 16) @(posedge clock);
      if (fail_count == 0)
         $display("trie_child_lookup_insert_unit: match");
      else
         $display("trie_child_lookup_insert_unit: mismatch");
      $finish;
   end

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_chan.ready <= 1'b0;
            hold_off = 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("trie_child_lookup_insert_unit: mismatch");
            $finish;
         end
      end
   end

endmodule
